[sv/timed_event_table_top_assert.svh]
// ----------------------------------------------------------------------------
// Timed event table assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_TABLE_TOP_ASSERT_SVH
`define TIMED_EVENT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define TET_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("timed_event_table: check failed");

// antecedent implies consequent in the same cycle
`define TET_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("timed_event_table: implication failed");

// antecedent implies consequent in the next cycle
`define TET_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("timed_event_table: next-cycle check failed");

`else

`define TET_ASSERT_ALWAYS(lbl, cond)
`define TET_ASSERT_IMPLIES(lbl, pre, post)
`define TET_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

[sv/tet_pkg.sv]
// ----------------------------------------------------------------------------
// Timed event table package
// Shared types, field widths and codes for the timed event table.
// ----------------------------------------------------------------------------
`default_nettype none

package tet_pkg;

  localparam int EVENT_W     = 16;
  localparam int DELAY_W     = 31;
  localparam int SLOT_W      = 3;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 88;  // 82 bits of fields, padded to bytes
  localparam int OUT_TDATA_W = 24;  // 19 bits of fields, padded to bytes
  localparam int QUEUE_DEPTH = 2;

  // input item selector
  typedef enum logic [MODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_SCHED = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_EV,
    S_SCAN_END,
    S_SCHED_ADD,
    S_SCHED_WR
  } state_t;

  // decoded command carried from front to back
  typedef struct packed {
    op_t                op;
    logic [EVENT_W-1:0] event_id;
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] active_span;
    logic               repeat_req;
    logic [SLOT_W-1:0]  slot;
    logic               clr_ok;     // clear names an existing slot
  } cmd_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic scanning;
    logic pend_v;
  } back_stat_t;

endpackage

`default_nettype wire

[sv/tet_fifo.sv]
// ----------------------------------------------------------------------------
// Timed event table command queue
// Short register queue of decoded commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_fifo import tet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[sv/tet_front.sv]
// ----------------------------------------------------------------------------
// Timed event table front end
// Accepts input items, unpacks and classifies them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_front import tet_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [MODE_W-1:0]     in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  logic [SLOT_W-1:0] slot;

  assign slot      = in_tdata[81:79];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.op          = op_t'(in_tuser);
    q_cmd.event_id    = in_tdata[15:0];
    q_cmd.start_delay = in_tdata[46:16];
    q_cmd.active_span = in_tdata[77:47];
    q_cmd.repeat_req  = in_tdata[78];
    q_cmd.slot        = slot;
    // slots past the table are acknowledged but ignored
    q_cmd.clr_ok      = ({29'd0, slot} < 32'(NUM_SLOTS));
  end

endmodule

`default_nettype wire

[sv/tet_back.sv]
// ----------------------------------------------------------------------------
// Timed event table back end
// Time counter, entry table and sequencer for tick, scan, schedule, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_back import tet_pkg::*; #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   q_head,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [KIND_W-1:0]           out_tuser,
  output logic                        out_tlast,
  output back_stat_t                  stat
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // entry table, no reset: read data is only used while the slot is valid
  logic [EVENT_W-1:0]   ev_mem    [NUM_SLOTS];
  logic [TIME_BITS-1:0] start_mem [NUM_SLOTS];
  logic [TIME_BITS-1:0] due_mem   [NUM_SLOTS];
  logic                 rep_mem   [NUM_SLOTS];

  logic [EVENT_W-1:0]   rd_ev_r;
  logic [TIME_BITS-1:0] rd_start_r;
  logic [TIME_BITS-1:0] rd_due_r;
  logic                 rd_rep_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;

  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [EVENT_W-1:0]   pend_ev_r, pend_ev_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  cmd_t                 cmd_r;

  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [EVENT_W-1:0]   out_ev_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_last_r;

  logic                 push;
  logic [KIND_W-1:0]    push_kind;
  logic [EVENT_W-1:0]   push_ev;
  logic [SLOT_W-1:0]    push_slot;
  logic                 push_last;

  logic                 out_free;
  logic                 idle_go;
  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;
  logic                 scan_hit;
  logic                 scan_kill;
  logic                 scan_adv;
  logic [IDX_W+SLOT_W-1:0]  head_slot_ext;
  logic [IDX_W-1:0]         head_slot_idx;
  logic [SLOT_W+IDX_W-1:0]  idx_ext;
  logic [SLOT_W-1:0]        idx_slot;
  logic [TIME_BITS+DELAY_W-1:0] dly_ext;
  logic [TIME_BITS+DELAY_W-1:0] span_ext;

  // width fitting between the 3-bit slot fields and the table index
  assign head_slot_ext = {{IDX_W{1'b0}}, q_head.slot};
  assign head_slot_idx = head_slot_ext[IDX_W-1:0];
  assign idx_ext       = {{SLOT_W{1'b0}}, idx_r};
  assign idx_slot      = idx_ext[SLOT_W-1:0];
  assign dly_ext       = {{TIME_BITS{1'b0}}, cmd_r.start_delay};
  assign span_ext      = {{TIME_BITS{1'b0}}, cmd_r.active_span};

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign idle_go   = (state_r == S_IDLE) && q_valid &&
                     (out_free || (q_head.op == OP_SCAN) ||
                      ((q_head.op == OP_SCHED) && free_any));
  assign scan_hit  = valid_r[idx_r] && (rd_start_r <= time_r);
  assign scan_kill = !rd_rep_r || (rd_due_r <= time_r);
  // a second firing needs the output register while one is still pending
  assign scan_adv  = (state_r == S_SCAN_EV) && !(scan_hit && pend_v_r && !out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (idle_go) begin
          if (q_head.op == OP_SCAN) begin
            state_nxt = S_SCAN_EV;
          end else if ((q_head.op == OP_SCHED) && free_any) begin
            state_nxt = S_SCHED_ADD;
          end
        end
      end
      S_SCAN_EV: begin
        if (scan_adv && (idx_r == LAST_IDX)) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCHED_ADD: begin
        state_nxt = S_SCHED_WR;
      end
      S_SCHED_WR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath control and results
  always_comb begin
    q_pop         = idle_go;
    push          = 1'b0;
    push_kind     = KIND_ACK;
    push_ev       = '0;
    push_slot     = '0;
    push_last     = 1'b1;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mem_we        = 1'b0;
    time_nxt      = time_r;
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_ev_nxt   = pend_ev_r;
    pend_slot_nxt = pend_slot_r;
    start_nxt     = start_r;
    unique case (state_r)
      S_IDLE: begin
        if (idle_go) begin
          unique case (q_head.op)
            OP_TICK: begin
              time_nxt = time_r + 1'b1;
              push     = 1'b1;
            end
            OP_SCAN: begin
              rd_en      = 1'b1;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
            end
            OP_SCHED: begin
              if (free_any) begin
                idx_nxt = free_idx;
              end else begin
                push      = 1'b1;
                push_kind = KIND_FULL;
              end
            end
            OP_CLEAR: begin
              if (q_head.clr_ok) begin
                valid_nxt[head_slot_idx] = 1'b0;
              end
              push      = 1'b1;
              push_slot = q_head.slot;
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      S_SCAN_EV: begin
        if (scan_adv) begin
          if (scan_hit) begin
            if (pend_v_r) begin
              push      = 1'b1;
              push_kind = KIND_FIRE;
              push_ev   = pend_ev_r;
              push_slot = pend_slot_r;
              push_last = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_ev_nxt   = rd_ev_r;
            pend_slot_nxt = idx_slot;
            if (scan_kill) begin
              valid_nxt[idx_r] = 1'b0;
            end
          end
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      S_SCAN_END: begin
        if (out_free) begin
          push       = 1'b1;
          pend_v_nxt = 1'b0;
          if (pend_v_r) begin
            push_kind = KIND_FIRE;
            push_ev   = pend_ev_r;
            push_slot = pend_slot_r;
          end
        end
      end
      S_SCHED_ADD: begin
        start_nxt = time_r + dly_ext[TIME_BITS-1:0];
      end
      S_SCHED_WR: begin
        if (out_free) begin
          mem_we         = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          push           = 1'b1;
          push_kind      = KIND_SCHED;
          push_slot      = idx_slot;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= push || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_ev_r   <= pend_ev_nxt;
    pend_slot_r <= pend_slot_nxt;
    start_r     <= start_nxt;
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (push) begin
      out_kind_r <= push_kind;
      out_ev_r   <= push_ev;
      out_slot_r <= push_slot;
      out_last_r <= push_last;
    end
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ev_mem[idx_r]    <= cmd_r.event_id;
      start_mem[idx_r] <= start_r;
      due_mem[idx_r]   <= start_r + span_ext[TIME_BITS-1:0];
      rep_mem[idx_r]   <= cmd_r.repeat_req;
    end
    if (rd_en) begin
      rd_ev_r    <= ev_mem[rd_addr];
      rd_start_r <= start_mem[rd_addr];
      rd_due_r   <= due_mem[rd_addr];
      rd_rep_r   <= rep_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - EVENT_W - SLOT_W){1'b0}}, out_slot_r, out_ev_r};

  assign stat.scanning = (state_r == S_SCAN_EV) || (state_r == S_SCAN_END);
  assign stat.pend_v   = pend_v_r;

endmodule

`default_nettype wire

[sv/timed_event_table_top.sv]
// ----------------------------------------------------------------------------
// Timed event table top level
// Millisecond counter with a table of one-shot and repeating timed events.
// ----------------------------------------------------------------------------
// The block keeps a TIME_BITS-wide millisecond count and NUM_SLOTS event
// entries. Each input item selects its operation in in_tuser: tick adds one to
// the count, scan walks the valid slots from slot 0 up and fires every entry
// whose start time has been reached, schedule fills the lowest free slot with
// start = now + delay and due = start + span, clear frees one slot. All times
// wrap and compare unsigned. Every item yields one result, except a scan with
// firings, which yields one result per fired slot in slot order, out_tlast
// marking the final one. Items enter a two-deep command queue, so the input
// side keeps accepting while the sequencer works or the output stalls, until
// the queue fills. The sequencer handles a tick, a clear or a full-table
// schedule in S_IDLE; a schedule adds the start in S_SCHED_ADD, then the due
// time and the table write in S_SCHED_WR; a scan runs S_SCAN_EV and S_SCAN_END,
// the entry table's single read port giving one slot per cycle unless a stalled
// output holds it. No clearing pass after reset; only table valid bits reset.
`default_nettype none

`include "timed_event_table_top_assert.svh"

module timed_event_table_top import tet_pkg::*; #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input items
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [15:0] event_id, [46:16] start_delay, [77:47] active_span,
  // [78] repeat_req, [81:79] slot, [87:82] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  wire logic [MODE_W-1:0]      in_tuser,
  // result items
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [15:0] fired_event, [18:16] slot_index, [23:19] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [1:0] kind
  output logic [KIND_W-1:0]           out_tuser,
  output logic                        out_tlast
);

  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  back_stat_t stat;

  // front: unpack and classify
  tet_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // command queue decoupling front and back
  tet_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head_cmd),
    .head_valid (q_valid)
  );

  // back: time count, table and result sequencing
  tet_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (head_cmd),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .stat       (stat)
  );

  // the sequencer never pops an empty queue
  `TET_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_valid)
  // input only back-pressures when the queue is full
  `TET_ASSERT_ALWAYS(a_ready_full, in_tready == !q_full)
  // a non-final firing is only shown mid-scan with a later firing held back
  `TET_ASSERT_IMPLIES(a_fire_pending, out_tvalid && (out_tuser == KIND_FIRE) && !out_tlast,
                      stat.scanning && stat.pend_v)
  // results other than firings carry no event number
  `TET_ASSERT_IMPLIES(a_event_zero, out_tvalid && (out_tuser != KIND_FIRE),
                      out_tdata[15:0] == 16'd0)

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Timed event table testbench
// Drives tick, scan, schedule and clear items into the timed event table and
// checks every result item against an in-bench model of the timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tet_pkg::*;

  localparam int NUM_SLOTS      = 8;
  localparam int TIME_BITS      = 32;
  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 155;
  localparam int HOLD_AT        = 60;    // item index where the long output stall starts
  localparam int HOLD_CYCLES    = 200;   // length of that stall
  localparam int HOLD_RUN       = 24;    // items sent back to back during the stall
  localparam int DRAIN_AT       = 130;   // item index where the sender waits for all results
  localparam int SETTLE_CYCLES  = 40;    // margin after the last owed result
  localparam int STALL_LIMIT    = 2000;  // cycles without any handshake before giving up

  // one input item, plus an optional typed-in result for the directed rows
  typedef struct {
    op_t                op;
    logic [EVENT_W-1:0] ev;
    logic [DELAY_W-1:0] dly;
    logic [DELAY_W-1:0] spn;
    logic               rep;
    logic [SLOT_W-1:0]  sl;
    logic               typed;     // 1: single result given by kind / slot_idx below
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot_idx;
  } stim_row_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [EVENT_W-1:0] fired;
    logic [SLOT_W-1:0]  slot_idx;
    logic               last;
  } timer_result_t;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [MODE_W-1:0]      in_tuser   = OP_TICK;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;

  // shadow copy of the timer table
  logic [TIME_BITS-1:0] time_ms = '0;
  logic                 slot_busy   [NUM_SLOTS];
  logic [EVENT_W-1:0]   slot_event  [NUM_SLOTS];
  logic [TIME_BITS-1:0] slot_start  [NUM_SLOTS];
  logic [TIME_BITS-1:0] slot_due    [NUM_SLOTS];
  logic                 slot_repeat [NUM_SLOTS];

  timer_result_t step_results[$];     // results of the item just accepted
  timer_result_t pending_results[$];  // results still owed by the DUT, oldest first

  int fail_count = 0;
  bit hold_req   = 1'b0;              // sender asks the receiver for a long stall

  // Directed rows. Time starts at 0; comments track the table as rows go by.
  stim_row_t directed_rows [DIRECTED_ITEMS] = '{
    '{OP_TICK,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},     // now 1
    '{OP_SCAN,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},     // empty table
    // clear of a free slot, other fields at their maximum and ignored
    '{OP_CLEAR, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 3'd7,
      1'b1, KIND_ACK, 3'd7},
    '{OP_TICK,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},     // now 2
    '{OP_SCHED, 16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_SCHED, 3'd0},   // once, due now
    '{OP_SCHED, 16'hFFFF, 31'd0, 31'd5, 1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd1},   // repeat, due 7
    // largest delay and span: due wraps past 2^32 to a small value
    '{OP_SCHED, 16'h1234, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 3'd0,
      1'b1, KIND_SCHED, 3'd2},
    '{OP_SCHED, 16'h00A5, 31'd3, 31'd0, 1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd3},   // start 5, due 5
    '{OP_SCAN,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b0, KIND_ACK, 3'd0},     // slots 0 and 1
    '{OP_TICK,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},
    '{OP_TICK,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},
    '{OP_TICK,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},     // now 5
    '{OP_SCAN,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b0, KIND_ACK, 3'd0},     // repeat expires
    '{OP_CLEAR, 16'h0000, 31'd0, 31'd0, 1'b0, 3'd1, 1'b1, KIND_ACK, 3'd1},     // only slot 2 left
    // fill every free slot, lowest first
    '{OP_SCHED, 16'h0101, 31'd0, 31'd0,   1'b0, 3'd0, 1'b1, KIND_SCHED, 3'd0},
    '{OP_SCHED, 16'h0202, 31'd0, 31'd10,  1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd1},
    '{OP_SCHED, 16'h0303, 31'd1, 31'd0,   1'b0, 3'd0, 1'b1, KIND_SCHED, 3'd3},
    '{OP_SCHED, 16'h0404, 31'd0, 31'd0,   1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd4},
    '{OP_SCHED, 16'h8000, 31'd0, 31'd3,   1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd5},
    '{OP_SCHED, 16'h7FFF, 31'd0, 31'd0,   1'b0, 3'd0, 1'b1, KIND_SCHED, 3'd6},
    '{OP_SCHED, 16'h5A5A, 31'd0, 31'd100, 1'b1, 3'd0, 1'b1, KIND_SCHED, 3'd7},
    // table full: slot_index reads zero whatever the item carries
    '{OP_SCHED, 16'hFFFF, 31'd0, 31'd0, 1'b1, 3'd7, 1'b1, KIND_FULL, 3'd0},
    '{OP_SCAN,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b0, KIND_ACK, 3'd0},     // six firings
    '{OP_CLEAR, 16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b1, KIND_ACK, 3'd0},     // already free
    '{OP_SCAN,  16'h0000, 31'd0, 31'd0, 1'b0, 3'd0, 1'b0, KIND_ACK, 3'd0}
  };

  timed_event_table_top #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Advance the shadow table by one accepted item; results land in step_results.
  task automatic timer_table_step(input stim_row_t c);
    logic [TIME_BITS-1:0] st;
    bit placed;
    placed = 1'b0;
    step_results.delete();
    case (c.op)
      OP_TICK: begin
        time_ms = time_ms + 1'b1;
        step_results.push_back('{KIND_ACK, 16'h0000, 3'd0, 1'b1});
      end
      OP_SCAN: begin
        // slot order; unsigned compare, so a wrapped start counts as reached
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i] && slot_start[i] <= time_ms) begin
            step_results.push_back('{KIND_FIRE, slot_event[i], SLOT_W'(i), 1'b0});
            if (!slot_repeat[i] || slot_due[i] <= time_ms) slot_busy[i] = 1'b0;
          end
        end
        if (step_results.size() == 0) begin
          step_results.push_back('{KIND_ACK, 16'h0000, 3'd0, 1'b1});
        end else begin
          step_results[step_results.size()-1].last = 1'b1;
        end
      end
      OP_SCHED: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !slot_busy[i]) begin
            st             = time_ms + TIME_BITS'(c.dly);
            slot_event[i]  = c.ev;
            slot_start[i]  = st;
            slot_due[i]    = st + TIME_BITS'(c.spn);
            slot_repeat[i] = c.rep;
            slot_busy[i]   = 1'b1;
            placed         = 1'b1;
            step_results.push_back('{KIND_SCHED, 16'h0000, SLOT_W'(i), 1'b1});
          end
        end
        if (!placed) step_results.push_back('{KIND_FULL, 16'h0000, 3'd0, 1'b1});
      end
      default: begin
        // the slot field cannot name anything beyond the 8-entry table
        slot_busy[c.sl] = 1'b0;
        step_results.push_back('{KIND_ACK, 16'h0000, c.sl, 1'b1});
      end
    endcase
  endtask

  // Random items: mostly short delays and spans so entries actually come due
  // within the few dozen milliseconds the run ticks through.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.op = OP_TICK;
    else if (pick < 60) r.op = OP_SCAN;
    else if (pick < 85) r.op = OP_SCHED;
    else                r.op = OP_CLEAR;
    r.ev       = EVENT_W'($urandom);
    r.dly      = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom)
                                             : DELAY_W'($urandom_range(0, 12));
    r.spn      = ($urandom_range(0, 4) == 0) ? DELAY_W'($urandom)
                                             : DELAY_W'($urandom_range(0, 30));
    r.rep      = 1'($urandom);
    r.sl       = SLOT_W'($urandom);
    r.typed    = 1'b0;
    r.kind     = KIND_ACK;
    r.slot_idx = 3'd0;
    return r;
  endfunction

  // Result checker: each accepted result item against the oldest owed one.
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d event %0h slot %0d last %0b",
               out_tuser, out_tdata[15:0], out_tdata[18:16], out_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata[15:0] !== want.fired) begin
          $error("fired_event: expected %0h, got %0h", want.fired, out_tdata[15:0]);
          fail_count++;
        end
        if (out_tdata[18:16] !== want.slot_idx) begin
          $error("slot_index: expected %0d, got %0d", want.slot_idx, out_tdata[18:16]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Receiver: switches among ready styles (always ready, mostly ready,
  // mostly stalled, or a random repeating 8-bit pattern), plus one long hold-off on
  // request so the command queue fills and in_tready drops.
  initial begin : result_sink
    int unsigned style;
    int unsigned left;
    logic [7:0]  pat;
    style = 0;
    left  = 0;
    pat   = 8'hFF;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = 40;
        pat   = 8'($urandom);
      end
      left--;
      case (style)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_tready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
    end
  end

  // Watchdog: gives up after too long without a handshake on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  // Sender: directed rows, then random items, in bursts with idle gaps between.
  initial begin : item_source
    stim_row_t   row;
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < DIRECTED_ITEMS + RANDOM_ITEMS; n++) begin
      row = (n < DIRECTED_ITEMS) ? directed_rows[n] : random_row();

      if (n == HOLD_AT) hold_req = 1'b1;

      if (n == DRAIN_AT) begin
        // stop and let every owed result come back before going on
        if (pending_results.size() != 0) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end else if (n >= HOLD_AT && n < HOLD_AT + HOLD_RUN) begin
        // back to back while the output is held, to fill the block
        burst_left = 0;
      end else if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end

      in_tvalid <= 1'b1;
      in_tuser  <= row.op;
      in_tdata  <= {6'b0, row.sl, row.rep, row.spn, row.dly, row.ev};
      @(posedge clk);
      while (!in_tready) @(posedge clk);

      // accepted at this edge
      timer_table_step(row);
      if (row.typed) begin
        pending_results.push_back('{row.kind, 16'h0000, row.slot_idx, 1'b1});
      end else begin
        foreach (step_results[k]) pending_results.push_back(step_results[k]);
      end
      if (burst_left != 0) burst_left--;
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
